// ----- hdl/sharpen_3x3_line_buffer_filter_macros.svh -----
// Assertion macros for the sharpen filter
`ifndef SHARPEN_3X3_LINE_BUFFER_FILTER_MACROS_SVH
`define SHARPEN_3X3_LINE_BUFFER_FILTER_MACROS_SVH

`ifndef SYNTH
`define SHF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("sharpen filter assertion failed");
`define SHF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sharpen filter assertion failed");
`else
`define SHF_ASSERT(lbl, prop)
`define SHF_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- hdl/sharp3_pkg.sv -----
// Shared constants, types and helper functions of the sharpen filter
`default_nettype none

package sharp3_pkg;

  localparam int LINE_WIDTH = 2048;
  localparam int COL_W      = $clog2(LINE_WIDTH);
  localparam int PIX_W      = 32;
  localparam int RGB_W      = 24;
  localparam int CH_W       = 8;
  localparam int SUM_W      = 12;
  localparam int NUM_BANKS  = 3;
  localparam int KEEP_W     = 4;

  typedef logic [1:0]       rot_t;
  typedef logic [COL_W-1:0] col_t;
  typedef logic [RGB_W-1:0] rgb_t;
  typedef logic [CH_W-1:0]  chan_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  localparam rot_t  ROT_0    = 2'd0;
  localparam rot_t  ROT_1    = 2'd1;
  localparam rot_t  ROT_2    = 2'd2;
  localparam col_t  COL_LAST = col_t'(LINE_WIDTH - 1);
  localparam chan_t CH_MAX   = 8'hFF;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
    col_t addr;
    rot_t wr_bank;
    rot_t old_bank;
    rot_t mid_bank;
    rgb_t wr_data;
  } mem_req_t;

  typedef struct packed {
    logic load;
    rot_t cold;
    rot_t cmid;
    rot_t cnew;
    rgb_t px;
  } win_ctl_t;

  typedef struct packed {
    sum_t blue;
    sum_t green;
    sum_t red;
  } sums_t;

  function automatic rot_t rot_inc(input rot_t r);
    return (r == ROT_2) ? ROT_0 : rot_t'(r + 2'd1);
  endfunction

  function automatic chan_t sat_abs(input sum_t s);
    logic [SUM_W-1:0] mag;
    mag = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
    return (mag > SUM_W'(CH_MAX)) ? CH_MAX : mag[CH_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- hdl/sharp3_line_store.sv -----
// Three rotating line store banks with a clearing sweep after reset
`default_nettype none

module sharp3_line_store (
  input  wire                   clk,
  input  wire                   rst,
  input  sharp3_pkg::mem_req_t  req,
  output logic                  busy,
  output sharp3_pkg::rgb_t      rd_old,
  output sharp3_pkg::rgb_t      rd_mid
);
  import sharp3_pkg::*;

  logic clearing;
  col_t clr_addr;
  rot_t old_sel;
  rot_t mid_sel;
  logic [NUM_BANKS-1:0][RGB_W-1:0] bank_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= col_t'(clr_addr + 1'b1);
      if (clr_addr == COL_LAST) begin
        clearing <= 1'b0;
      end
    end
  end

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    logic [RGB_W-1:0] mem [LINE_WIDTH];
    rgb_t             q;

    always_ff @(posedge clk) begin
      if (clearing) begin
        mem[clr_addr] <= '0;
      end else if (req.wr_en && req.wr_bank == rot_t'(b)) begin
        mem[req.addr] <= req.wr_data;
      end
      if (req.rd_en) begin
        q <= mem[req.addr];
      end
    end

    assign bank_q[b] = q;
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      old_sel <= req.old_bank;
      mid_sel <= req.mid_bank;
    end
  end

  function automatic rgb_t pick(input rot_t sel);
    case (sel)
      ROT_0:   return bank_q[0];
      ROT_1:   return bank_q[1];
      default: return bank_q[2];
    endcase
  endfunction

  assign busy = clearing;

  always_comb begin
    rd_old = pick(old_sel);
    rd_mid = pick(mid_sel);
  end

endmodule

`default_nettype wire

// ----- hdl/sharp3_window.sv -----
// 3x3 pixel window with per-channel sharpen sums
`default_nettype none

module sharp3_window (
  input  wire                   clk,
  input  wire                   rst,
  input  sharp3_pkg::win_ctl_t  ctl,
  input  sharp3_pkg::rgb_t      rd_old,
  input  sharp3_pkg::rgb_t      rd_mid,
  output sharp3_pkg::sums_t     sums
);
  import sharp3_pkg::*;

  typedef logic [2:0][RGB_W-1:0] wcol_t;

  wcol_t col0;
  wcol_t col1;
  wcol_t col2;
  wcol_t mid_col;
  wcol_t old_col;
  wcol_t new_col;
  sums_t sums_next;

  function automatic wcol_t pick(input rot_t sel, input wcol_t a, input wcol_t b,
                                 input wcol_t c);
    case (sel)
      ROT_0:   return a;
      ROT_1:   return b;
      default: return c;
    endcase
  endfunction

  function automatic sum_t chan_sum(input chan_t c, input chan_t u, input chan_t d,
                                    input chan_t l, input chan_t r);
    logic [SUM_W-1:0] acc;
    acc = SUM_W'({c, 2'b00}) + SUM_W'(c) - SUM_W'(u) - SUM_W'(d) - SUM_W'(l) - SUM_W'(r);
    return sum_t'(acc);
  endfunction

  assign new_col = {ctl.px, rd_mid, rd_old};
  assign mid_col = pick(ctl.cmid, col0, col1, col2);
  assign old_col = pick(ctl.cold, col0, col1, col2);

  always_comb begin
    sums_next.red   = chan_sum(mid_col[1][7:0],   mid_col[0][7:0],   mid_col[2][7:0],
                               old_col[1][7:0],   rd_mid[7:0]);
    sums_next.green = chan_sum(mid_col[1][15:8],  mid_col[0][15:8],  mid_col[2][15:8],
                               old_col[1][15:8],  rd_mid[15:8]);
    sums_next.blue  = chan_sum(mid_col[1][23:16], mid_col[0][23:16], mid_col[2][23:16],
                               old_col[1][23:16], rd_mid[23:16]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col0 <= '0;
      col1 <= '0;
      col2 <= '0;
    end else if (ctl.load) begin
      case (ctl.cnew)
        ROT_0:   col0 <= new_col;
        ROT_1:   col1 <= new_col;
        default: col2 <= new_col;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sums <= sums_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/sharpen_3x3_line_buffer_filter.sv -----
// Top level of the 3x3 sharpen filter over a line-buffered RGB stream
//
//  Channel | Handshake           | Fields
//  --------+---------------------+-----------------------------------------------
//  in      | in_valid / in_ready | pixel, frame_start, line_end, bypass,
//          |                     | byte_keep, stream_id, stream_dest
//  out     | out_valid/out_ready | pixel_out, frame_start_out, line_end_out,
//          |                     | byte_keep_out, stream_id_out, stream_dest_out
//
//  One item per cycle unless the output stalls or the line stores are clearing;
//  each result passes the read, window and output registers in that order.
//  Line store banks are read and written in the cycle an item is taken.
//  After reset the line stores are swept to zero over all LINE_WIDTH
//  addresses (2048), during which in_ready stays low.
//  A stalled output holds its stage; earlier stages keep filling bubbles.
`default_nettype none
`include "sharpen_3x3_line_buffer_filter_macros.svh"

module sharpen_3x3_line_buffer_filter (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [31:0] pixel,
  input  wire         frame_start,
  input  wire         line_end,
  input  wire         bypass,
  input  wire  [3:0]  byte_keep,
  input  wire         stream_id,
  input  wire         stream_dest,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [31:0] pixel_out,
  output logic        frame_start_out,
  output logic        line_end_out,
  output logic [3:0]  byte_keep_out,
  output logic        stream_id_out,
  output logic        stream_dest_out
);
  import sharp3_pkg::*;

  typedef struct packed {
    logic [PIX_W-1:0]  pixel;
    logic              frame_start;
    logic              line_end;
    logic [KEEP_W-1:0] byte_keep;
    logic              stream_id;
    logic              stream_dest;
    logic              pass;
  } side_t;

  col_t       col_count;
  logic [1:0] row_count;
  rot_t       col_rot;
  rot_t       row_rot;

  col_t       x;
  logic [1:0] row_eff;
  rot_t       crot_eff;
  rot_t       r_old;
  rot_t       r_mid;
  rot_t       r_new;
  logic       accept;
  logic       en1;
  logic       en2;
  logic       en3;
  logic       mem_busy;
  logic       col_run;
  side_t      in_side;

  logic       s1_valid;
  side_t      s1_side;
  rot_t       s1_cold;
  logic       s2_valid;
  side_t      s2_side;

  mem_req_t   mem_req;
  win_ctl_t   win_ctl;
  rgb_t       rd_old;
  rgb_t       rd_mid;
  sums_t      sums;

  assign en3      = !out_valid || out_ready;
  assign en2      = !s2_valid || en3;
  assign en1      = !s1_valid || en2;
  assign in_ready = en1 && !mem_busy;
  assign accept   = in_valid && in_ready;
  assign col_run  = accept && !frame_start && !line_end && col_count != COL_LAST;

  assign x        = frame_start ? '0 : col_count;
  assign row_eff  = frame_start ? 2'd0 : row_count;
  assign crot_eff = frame_start ? ROT_0 : col_rot;
  assign r_old    = frame_start ? ROT_0 : row_rot;
  assign r_mid    = rot_inc(r_old);
  assign r_new    = rot_inc(r_mid);

  always_comb begin
    in_side.pixel       = pixel;
    in_side.frame_start = frame_start;
    in_side.line_end    = line_end;
    in_side.byte_keep   = byte_keep;
    in_side.stream_id   = stream_id;
    in_side.stream_dest = stream_dest;
    in_side.pass        = (x <= col_t'(1)) || (row_eff <= 2'd1) || bypass;
  end

  always_comb begin
    mem_req.wr_en    = accept;
    mem_req.rd_en    = accept;
    mem_req.addr     = x;
    mem_req.wr_bank  = r_new;
    mem_req.old_bank = r_old;
    mem_req.mid_bank = r_mid;
    mem_req.wr_data  = pixel[RGB_W-1:0];
  end

  always_comb begin
    win_ctl.load = s1_valid && en2;
    win_ctl.cold = s1_cold;
    win_ctl.cmid = rot_inc(s1_cold);
    win_ctl.cnew = rot_inc(rot_inc(s1_cold));
    win_ctl.px   = s1_side.pixel[RGB_W-1:0];
  end

  sharp3_line_store u_line_store (
    .clk    (clk),
    .rst    (rst),
    .req    (mem_req),
    .busy   (mem_busy),
    .rd_old (rd_old),
    .rd_mid (rd_mid)
  );

  sharp3_window u_window (
    .clk    (clk),
    .rst    (rst),
    .ctl    (win_ctl),
    .rd_old (rd_old),
    .rd_mid (rd_mid),
    .sums   (sums)
  );

  // advance counters and stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= 2'd0;
      col_rot   <= ROT_0;
      row_rot   <= ROT_0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        col_rot <= rot_inc(crot_eff);
        if (line_end) begin
          col_count <= '0;
          row_count <= (row_eff < 2'd2) ? 2'(row_eff + 2'd1) : row_eff;
          row_rot   <= r_mid;
        end else begin
          col_count <= (x < COL_LAST) ? col_t'(x + 1'b1) : x;
          row_count <= row_eff;
          row_rot   <= r_old;
        end
      end
      if (en1) begin
        s1_valid <= accept;
      end
      if (en2) begin
        s2_valid <= s1_valid;
      end
      if (en3) begin
        out_valid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_side <= in_side;
      s1_cold <= crot_eff;
    end
    if (en2 && s1_valid) begin
      s2_side <= s1_side;
    end
    if (en3 && s2_valid) begin
      pixel_out       <= s2_side.pass ? s2_side.pixel :
                         {8'h00, sat_abs(sums.blue), sat_abs(sums.green), sat_abs(sums.red)};
      frame_start_out <= s2_side.frame_start;
      line_end_out    <= s2_side.line_end;
      byte_keep_out   <= s2_side.byte_keep;
      stream_id_out   <= s2_side.stream_id;
      stream_dest_out <= s2_side.stream_dest;
    end
  end

  `SHF_ASSERT(a_rot_range, col_rot != 2'd3 && row_rot != 2'd3 && row_count != 2'd3)
  `SHF_ASSERT(a_no_take_while_clearing, !(mem_busy && accept))
  `SHF_ASSERT_NEXT(a_col_step, col_run, col_count == col_t'($past(col_count) + 1'b1))
  `SHF_ASSERT_NEXT(a_s1_hold, s1_valid && !en2, s1_valid)
  `SHF_ASSERT_NEXT(a_out_source, !out_valid && !s2_valid, !out_valid)

endmodule

`default_nettype wire
